// ===== design/csstrip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csstrip_pkg
// shared types and character codes for the comment stripper
// ----------------------------------------------------------------------------
package csstrip_pkg;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// depth of the queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPW    = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		M_NORMAL     = 4'd0,
		M_SLASH      = 4'd1,
		M_LINE       = 4'd2,
		M_BLOCK      = 4'd3,
		M_BLOCK_STAR = 4'd4,
		M_Q1         = 4'd5,
		M_Q2         = 4'd6,
		M_STR        = 4'd7,
		M_RAW_OPEN   = 4'd8,
		M_RAW_BODY   = 4'd9
	} mode_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_end;
		logic       stream_end;
	} out_item_t;

	// one queue entry: the one or two words caused by one input byte
	typedef struct packed {
		logic       two;
		logic [7:0] c0;
		logic [7:0] c1;
		logic       last;
	} entry_t;

	// handshake between queue and its neighbors
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== design/source_comment_stripper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_comment_stripper_top
// streaming comment remover for c#-like source text, one byte per word
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  src     | in        | src_valid/src_stall | in_item_t  (in_char, in_last)
//  dst     | out       | dst_valid/dst_stall | out_item_t (out_char, run_end, stream_end)
//
//  a source byte is taken every cycle while the queue has room; the scanner
//  state updates in that same cycle and 0..2 output words are queued
//  output words leave one per cycle from a registered output stage while dst_stall
//  is low, so the two words of a byte that yields two leave one after the other
//  src_stall rises only when the four-entry queue is full
//  reset clears scanner mode, raw quote counts, queue pointers and out valid
// ----------------------------------------------------------------------------
module source_comment_stripper_top import csstrip_pkg::*; #(
	parameter int unsigned MAX_RAW_QUOTES = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_word,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_word
);

	logic    take;
	logic    push;
	logic    pop;
	entry_t  new_entry;
	entry_t  head_entry;
	q_ctrl_t q_ctrl;
	q_stat_t q_stat;

	// accept a byte whenever the queue can hold its words
	assign src_stall = q_stat.full;
	assign take      = src_valid && !q_stat.full;

	assign q_ctrl.push = push;
	assign q_ctrl.pop  = pop;

	// front: mode tracking and word forming
	csstrip_front #(
		.MAX_RAW_QUOTES(MAX_RAW_QUOTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (src_word),
		.push   (push),
		.entry  (new_entry)
	);

	// decoupling queue
	csstrip_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.wr_entry (new_entry),
		.rd_entry (head_entry),
		.stat     (q_stat)
	);

	// back: serializes word groups onto the output
	csstrip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_entry),
		.stat      (q_stat),
		.pop       (pop),
		.out_valid (dst_valid),
		.out_stall (dst_stall),
		.out_word  (dst_word)
	);

endmodule

// ===== design/csstrip_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csstrip_front
// scanner: tracks comment/string mode and forms the words for each byte
// ----------------------------------------------------------------------------
module csstrip_front import csstrip_pkg::*; #(
	parameter int unsigned MAX_RAW_QUOTES = 15
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_item_t item,
	output logic     push,
	output entry_t   entry
);

	localparam int unsigned CW = $clog2(MAX_RAW_QUOTES + 1);
	localparam logic [CW-1:0] MAXQ = CW'(MAX_RAW_QUOTES);
	localparam logic [CW-1:0] OPEN3 = CW'(3);

	typedef struct packed {
		logic  emit;
		logic  clr_bs;
		mode_t mode;
	} nb_t;

	mode_t         mode_q, mode_n;
	logic [CW-1:0] open_q, open_n;
	logic [CW-1:0] close_q, close_n;
	logic [CW-1:0] close_inc;
	logic          bs_q, bs_n;
	logic          e_pre, e_mid, e_post;
	logic [7:0]    mid_ch;
	logic [7:0]    c;
	nb_t           nb;

	// plain text handling of one byte
	function automatic nb_t normal_byte(input logic [7:0] ch);
		nb_t r;
		r.emit   = 1'b1;
		r.clr_bs = 1'b0;
		r.mode   = M_NORMAL;
		if (ch == CH_SLASH) begin
			r.emit = 1'b0;
			r.mode = M_SLASH;
		end else if (ch == CH_QUOTE) begin
			r.clr_bs = 1'b1;
			r.mode   = M_Q1;
		end
		return r;
	endfunction

	assign c         = item.in_char;
	assign nb        = normal_byte(c);
	assign close_inc = (close_q < MAXQ) ? close_q + 1'b1 : close_q;

	always_comb begin
		mode_n  = mode_q;
		open_n  = open_q;
		close_n = close_q;
		bs_n    = bs_q;
		e_pre   = 1'b0;
		e_mid   = 1'b0;
		mid_ch  = c;
		case (mode_q)
			M_SLASH: begin
				if (c == CH_SLASH) begin
					e_mid  = 1'b1;
					mid_ch = CH_LF;
					bs_n   = 1'b0;
					mode_n = M_LINE;
				end else if (c == CH_STAR) begin
					e_mid  = 1'b1;
					mid_ch = CH_SPACE;
					mode_n = M_BLOCK;
				end else begin
					// lone slash: flush it, then rescan this byte
					e_pre  = 1'b1;
					e_mid  = nb.emit;
					mode_n = nb.mode;
					if (nb.clr_bs) bs_n = 1'b0;
				end
			end
			M_LINE: begin
				if (c == CH_LF && !bs_q) mode_n = M_NORMAL;
				bs_n = (c == CH_BSLASH);
			end
			M_BLOCK: begin
				if (c == CH_STAR) mode_n = M_BLOCK_STAR;
			end
			M_BLOCK_STAR: begin
				if (c == CH_SLASH) mode_n = M_NORMAL;
				else if (c != CH_STAR) mode_n = M_BLOCK;
			end
			M_Q1: begin
				e_mid = 1'b1;
				if (c == CH_QUOTE) begin
					mode_n = M_Q2;
				end else begin
					bs_n   = (c == CH_BSLASH);
					mode_n = M_STR;
				end
			end
			M_Q2: begin
				if (c == CH_QUOTE) begin
					e_mid   = 1'b1;
					open_n  = OPEN3;
					close_n = '0;
					mode_n  = M_RAW_OPEN;
				end else begin
					// empty string closed, rescan this byte
					e_mid  = nb.emit;
					mode_n = nb.mode;
					if (nb.clr_bs) bs_n = 1'b0;
				end
			end
			M_STR: begin
				e_mid = 1'b1;
				if (bs_q) bs_n = 1'b0;
				else if (c == CH_QUOTE) mode_n = M_NORMAL;
				else if (c == CH_BSLASH) bs_n = 1'b1;
			end
			M_RAW_OPEN: begin
				e_mid = 1'b1;
				if (c == CH_QUOTE) begin
					if (open_q < MAXQ) open_n = open_q + 1'b1;
				end else begin
					close_n = '0;
					mode_n  = M_RAW_BODY;
				end
			end
			M_RAW_BODY: begin
				e_mid = 1'b1;
				if (c == CH_QUOTE) begin
					if (close_inc >= open_q) begin
						close_n = '0;
						open_n  = '0;
						mode_n  = M_NORMAL;
					end else begin
						close_n = close_inc;
					end
				end else begin
					close_n = '0;
				end
			end
			default: begin
				e_mid  = nb.emit;
				mode_n = nb.mode;
				if (nb.clr_bs) bs_n = 1'b0;
			end
		endcase
		// held slash at stream end is flushed
		e_post = item.in_last && (mode_n == M_SLASH);
		if (item.in_last) begin
			mode_n  = M_NORMAL;
			open_n  = '0;
			close_n = '0;
			bs_n    = 1'b0;
		end
	end

	// pack up to two words in order: pre slash, main word, flushed slash
	always_comb begin
		entry.two  = (e_pre && e_mid) || ((e_pre || e_mid) && e_post);
		entry.c0   = e_pre ? CH_SLASH : (e_mid ? mid_ch : CH_SLASH);
		entry.c1   = (e_pre && e_mid) ? mid_ch : CH_SLASH;
		entry.last = item.in_last;
		push       = take && (e_pre || e_mid || e_post);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			open_q  <= '0;
			close_q <= '0;
			bs_q    <= 1'b0;
		end else if (take) begin
			mode_q  <= mode_n;
			open_q  <= open_n;
			close_q <= close_n;
			bs_q    <= bs_n;
		end
	end

endmodule

// ===== design/csstrip_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csstrip_queue
// short fifo of word groups between scanner and output side
// ----------------------------------------------------------------------------
module csstrip_queue import csstrip_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_ctrl_t ctrl,
	input  entry_t  wr_entry,
	output entry_t  rd_entry,
	output q_stat_t stat
);

	entry_t           mem_q [QDEPTH];
	logic [QPW-1:0]   wp_q, rp_q;
	logic [QPW:0]     cnt_q;
	logic             do_push, do_pop;

	assign stat.full  = (cnt_q == (QPW+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = ctrl.push && !stat.full;
	assign do_pop     = ctrl.pop && !stat.empty;
	assign rd_entry   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/csstrip_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csstrip_back
// output side: unpacks queued word groups into single words
// ----------------------------------------------------------------------------
module csstrip_back import csstrip_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  entry_t    head,
	input  q_stat_t   stat,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_word
);

	logic      valid_q;
	out_item_t word_q;
	logic      sel_q;
	logic      load;
	logic      final_word;

	assign load       = (!valid_q || !out_stall) && !stat.empty;
	assign final_word = !head.two || sel_q;
	assign pop        = load && final_word;
	assign out_valid  = valid_q;
	assign out_word   = word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q.out_char   <= sel_q ? head.c1 : head.c0;
			word_q.run_end    <= final_word;
			word_q.stream_end <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !final_word;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/stripper_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stripper_checker
// watches both channels of the comment stripper, predicts the words that each
// accepted source byte yields and compares them with the words that leave it
// ----------------------------------------------------------------------------
module stripper_checker import csstrip_pkg::*; #(
	parameter int unsigned MAX_RAW_QUOTES = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	input  logic        src_stall,
	input  in_item_t    src_word,
	input  logic        dst_valid,
	input  logic        dst_stall,
	input  out_item_t   dst_word,
	output int unsigned mismatches = 0,
	output int unsigned pending = 0,
	output int unsigned checked = 0
);

	// scanner state as the block should hold it
	mode_t       mode;
	int unsigned raw_open;
	int unsigned raw_run;
	logic        esc;

	logic [7:0] step_chars[$];
	out_item_t  expected_words[$];

	task automatic emit_char(input logic [7:0] c);
		if (step_chars.size() < 2)
			step_chars.push_back(c);
	endtask

	// byte seen in normal text
	task automatic plain_char(input logic [7:0] c);
		if (c == CH_SLASH) begin
			mode = M_SLASH;
		end else begin
			emit_char(c);
			if (c == CH_QUOTE) begin
				esc  = 1'b0;
				mode = M_Q1;
			end else begin
				mode = M_NORMAL;
			end
		end
	endtask

	task automatic strip_byte(input in_item_t w);
		logic [7:0] c;
		out_item_t  o;
		c = w.in_char;
		step_chars.delete();
		case (mode)
			M_SLASH: begin
				if (c == CH_SLASH) begin
					emit_char(CH_LF);
					esc  = 1'b0;
					mode = M_LINE;
				end else if (c == CH_STAR) begin
					emit_char(CH_SPACE);
					mode = M_BLOCK;
				end else begin
					// lone slash, then the byte counts again as normal text
					emit_char(CH_SLASH);
					plain_char(c);
				end
			end
			M_LINE: begin
				if (c == CH_LF && !esc)
					mode = M_NORMAL;
				esc = (c == CH_BSLASH);
			end
			M_BLOCK: begin
				if (c == CH_STAR)
					mode = M_BLOCK_STAR;
			end
			M_BLOCK_STAR: begin
				if (c == CH_SLASH)
					mode = M_NORMAL;
				else if (c != CH_STAR)
					mode = M_BLOCK;
			end
			M_Q1: begin
				emit_char(c);
				if (c == CH_QUOTE) begin
					mode = M_Q2;
				end else begin
					esc  = (c == CH_BSLASH);
					mode = M_STR;
				end
			end
			M_Q2: begin
				if (c == CH_QUOTE) begin
					emit_char(c);
					raw_open = 3;
					raw_run  = 0;
					mode     = M_RAW_OPEN;
				end else begin
					plain_char(c);
				end
			end
			M_STR: begin
				emit_char(c);
				if (esc)
					esc = 1'b0;
				else if (c == CH_QUOTE)
					mode = M_NORMAL;
				else if (c == CH_BSLASH)
					esc = 1'b1;
			end
			M_RAW_OPEN: begin
				emit_char(c);
				if (c == CH_QUOTE) begin
					if (raw_open < MAX_RAW_QUOTES)
						raw_open++;
				end else begin
					raw_run = 0;
					mode    = M_RAW_BODY;
				end
			end
			M_RAW_BODY: begin
				emit_char(c);
				if (c == CH_QUOTE) begin
					if (raw_run < MAX_RAW_QUOTES)
						raw_run++;
					if (raw_run >= raw_open) begin
						raw_run  = 0;
						raw_open = 0;
						mode     = M_NORMAL;
					end
				end else begin
					raw_run = 0;
				end
			end
			default: plain_char(c);
		endcase
		if (w.in_last) begin
			// a held slash is flushed, everything else is dropped
			if (mode == M_SLASH)
				emit_char(CH_SLASH);
			mode     = M_NORMAL;
			raw_open = 0;
			raw_run  = 0;
			esc      = 1'b0;
		end
		foreach (step_chars[k]) begin
			o.out_char   = step_chars[k];
			o.run_end    = (k == step_chars.size() - 1);
			o.stream_end = w.in_last;
			expected_words.push_back(o);
		end
	endtask

	function automatic void compare_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t  %s mismatch: expected %02h, got %02h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode     = M_NORMAL;
			raw_open = 0;
			raw_run  = 0;
			esc      = 1'b0;
			expected_words.delete();
		end else begin
			if (dst_valid && !dst_stall) begin
				checked++;
				if (expected_words.size() == 0) begin
					mismatches++;
					$display("%0t  word %02h/%b/%b arrived, expected none",
						$time, dst_word.out_char, dst_word.run_end, dst_word.stream_end);
				end else begin
					compare_field("out_char", expected_words[0].out_char, dst_word.out_char);
					compare_field("run_end", 8'(expected_words[0].run_end),
						8'(dst_word.run_end));
					compare_field("stream_end", 8'(expected_words[0].stream_end),
						8'(dst_word.stream_end));
					void'(expected_words.pop_front());
				end
			end
			if (src_valid && !src_stall)
				strip_byte(src_word);
		end
		pending = expected_words.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the comment stripper: a short directed pass over
// the corner cases, then random streams built mostly from well-formed c#
// fragments (comments, strings, raw strings) with noise and cut-off streams
// mixed in; a separate checker predicts and compares every output word
// ----------------------------------------------------------------------------
module tb;
	import csstrip_pkg::*;

	localparam int unsigned MAX_RAW_QUOTES = 15;
	localparam int unsigned RANDOM_WORDS   = 1250;  // counted bytes in the random part
	localparam int unsigned HOLD_CYCLES    = 60;    // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES   = 20;    // settle time at the end
	localparam longint     RUN_LIMIT_NS   = 3_000_000;

	// receiver stall patterns
	typedef enum logic [2:0] {
		RX_FREE,
		RX_HALF,
		RX_QUARTER,
		RX_EVERY_THIRD,
		RX_HEAVY
	} stall_style_t;

	// kinds of source fragment
	typedef enum logic [2:0] {
		FR_PLAIN,
		FR_LINE,
		FR_BLOCK,
		FR_STRING,
		FR_EMPTY_STR,
		FR_RAW,
		FR_LONE_SLASH,
		FR_NOISE
	} frag_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_item_t  src_word  = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	out_item_t dst_word;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned checked;

	// stimulus bookkeeping
	logic [7:0]  text[$];
	int unsigned counted    = 0;
	int unsigned streams    = 0;
	int unsigned bytes_sent = 0;
	int unsigned burst_left = 0;
	logic        no_idle    = 1'b0;
	logic        hold_tog   = 1'b0;

	// receiver bookkeeping
	int unsigned  rx_cycle  = 0;
	int unsigned  hold_left = 0;
	logic         hold_seen = 1'b0;
	stall_style_t rx_style  = RX_FREE;

	source_comment_stripper_top #(
		.MAX_RAW_QUOTES(MAX_RAW_QUOTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word (src_word),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_word (dst_word)
	);

	stripper_checker #(
		.MAX_RAW_QUOTES(MAX_RAW_QUOTES)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word),
		.mismatches(mismatches),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs or words go missing
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: a stall pattern that is drawn anew at random from time to time, plus a long
	// hold-off whenever the stimulus side toggles hold_tog
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 256 == 0)
			rx_style <= stall_style_t'($urandom_range(0, 4));
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dst_stall <= 1'b1;
		end else if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES - 1;
			dst_stall <= 1'b1;
		end else begin
			case (rx_style)
				RX_FREE:        dst_stall <= 1'b0;
				RX_HALF:        dst_stall <= ($urandom_range(0, 1) == 0);
				RX_QUARTER:     dst_stall <= ($urandom_range(0, 3) == 0);
				RX_EVERY_THIRD: dst_stall <= (rx_cycle % 3 == 0);
				default:        dst_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// queue one byte of the next stream
	task automatic put(input logic [7:0] c, input logic counts);
		text.push_back(c);
		if (counts)
			counted++;
	endtask

	// mostly printable text, sometimes a syntax character or any byte at all
	function automatic logic [7:0] text_char();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 8'($urandom_range(8'h20, 8'h7E));
		if (r == 7) begin
			case ($urandom_range(0, 3))
				0:       return CH_STAR;
				1:       return CH_BSLASH;
				2:       return CH_QUOTE;
				default: return CH_SLASH;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_fragment();
		frag_t       kind;
		int unsigned r;
		int unsigned n;
		int unsigned eff;
		logic [7:0]  c;
		logic [7:0]  prev;
		r = $urandom_range(0, 99);
		if (r < 22)      kind = FR_PLAIN;
		else if (r < 35) kind = FR_LINE;
		else if (r < 48) kind = FR_BLOCK;
		else if (r < 63) kind = FR_STRING;
		else if (r < 69) kind = FR_EMPTY_STR;
		else if (r < 80) kind = FR_RAW;
		else if (r < 90) kind = FR_LONE_SLASH;
		else             kind = FR_NOISE;
		case (kind)
			FR_PLAIN: begin
				repeat ($urandom_range(1, 8)) begin
					c = 8'($urandom_range(8'h20, 8'h7E));
					if (c == CH_SLASH || c == CH_QUOTE)
						c = 8'h70;
					if ($urandom_range(0, 7) == 0)
						c = CH_LF;
					put(c, 1'b1);
				end
			end
			FR_LINE: begin
				put(CH_SLASH, 1'b1);
				put(CH_SLASH, 1'b1);
				repeat ($urandom_range(0, 8)) begin
					c = text_char();
					put((c == CH_LF) ? 8'h2E : c, 1'b0);
					// backslash before the newline keeps the comment going,
					// doubled or not
					if ($urandom_range(0, 7) == 0) begin
						put(CH_BSLASH, 1'b0);
						if ($urandom_range(0, 1) == 0)
							put(CH_BSLASH, 1'b0);
						put(CH_LF, 1'b0);
					end
				end
				put(CH_LF, 1'b0);
			end
			FR_BLOCK: begin
				put(CH_SLASH, 1'b1);
				put(CH_STAR, 1'b1);
				prev = 8'h00;
				// a slash right after the opener must not close it
				if ($urandom_range(0, 3) == 0) begin
					put(CH_SLASH, 1'b0);
					prev = CH_SLASH;
				end
				repeat ($urandom_range(0, 10)) begin
					c = text_char();
					if (prev == CH_STAR && c == CH_SLASH)
						c = 8'h2E;
					put(c, 1'b0);
					prev = c;
				end
				put(CH_STAR, 1'b0);
				put(CH_SLASH, 1'b0);
			end
			FR_STRING: begin
				put(CH_QUOTE, 1'b1);
				repeat ($urandom_range(0, 8)) begin
					case ($urandom_range(0, 5))
						0: begin
							put(CH_BSLASH, 1'b1);
							put(CH_QUOTE, 1'b1);
						end
						1: begin
							put(CH_BSLASH, 1'b1);
							put(CH_BSLASH, 1'b1);
						end
						default: begin
							c = text_char();
							put((c == CH_QUOTE || c == CH_BSLASH) ? 8'h71 : c, 1'b1);
						end
					endcase
				end
				put(CH_QUOTE, 1'b1);
			end
			FR_EMPTY_STR: begin
				put(CH_QUOTE, 1'b1);
				put(CH_QUOTE, 1'b1);
				put(text_char(), 1'b1);
			end
			FR_RAW: begin
				// openers past the maximum saturate the count
				n   = $urandom_range(3, MAX_RAW_QUOTES + 3);
				eff = (n > MAX_RAW_QUOTES) ? MAX_RAW_QUOTES : n;
				repeat (n) put(CH_QUOTE, 1'b1);
				put(8'h72, 1'b1);
				repeat ($urandom_range(1, 12)) begin
					if ($urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(1, eff - 1)) put(CH_QUOTE, 1'b1);
						put(8'h72, 1'b1);
					end else begin
						c = 8'($urandom_range(0, 255));
						put((c == CH_QUOTE) ? 8'h72 : c, 1'b1);
					end
				end
				repeat (eff) put(CH_QUOTE, 1'b1);
			end
			FR_LONE_SLASH: begin
				put(CH_SLASH, 1'b1);
				c = text_char();
				put((c == CH_SLASH || c == CH_STAR) ? 8'h6B : c, 1'b1);
			end
			default: begin
				repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
	endtask

	// offer one word, with a random gap at the start of each burst
	task automatic send_byte(input logic [7:0] c, input logic last);
		in_item_t    w;
		int unsigned gap;
		w.in_char = c;
		w.in_last = last;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = no_idle ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		src_valid <= 1'b1;
		src_word  <= w;
		do @(posedge clk); while (src_stall);
		bytes_sent++;
	endtask

	// send the queued text as one stream, last flag on its final byte
	task automatic send_text();
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1);
		text.delete();
		streams++;
	endtask

	task automatic go_idle();
		src_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned cut;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme byte values around a lone slash
		put(8'h00, 1'b1);
		put(CH_SLASH, 1'b1);
		put(8'hFF, 1'b1);
		send_text();
		// line comment carried over a newline by a backslash
		put(CH_SLASH, 1'b1);
		put(CH_SLASH, 1'b1);
		put(CH_BSLASH, 1'b1);
		put(CH_LF, 1'b1);
		put(CH_LF, 1'b1);
		put(8'h7A, 1'b1);
		send_text();
		// slash-star-slash does not close the block comment
		put(CH_SLASH, 1'b1);
		put(CH_STAR, 1'b1);
		put(CH_SLASH, 1'b1);
		put(8'h78, 1'b1);
		put(CH_STAR, 1'b1);
		put(CH_SLASH, 1'b1);
		send_text();
		// empty string, then the next byte as normal text
		put(CH_QUOTE, 1'b1);
		put(CH_QUOTE, 1'b1);
		put(8'h61, 1'b1);
		send_text();
		// shortest raw string
		repeat (3) put(CH_QUOTE, 1'b1);
		put(8'h78, 1'b1);
		repeat (3) put(CH_QUOTE, 1'b1);
		send_text();
		// a held slash as the whole stream gets flushed
		put(CH_SLASH, 1'b1);
		send_text();

		// sender waits until every word has come out
		go_idle();
		wait (pending == 0);

		counted = 0;
		while (counted < RANDOM_WORDS) begin
			if (streams % 40 == 7) begin
				// long receiver hold-off while a steady stream fills the block
				no_idle = 1'b1;
				hold_tog <= ~hold_tog;
				repeat (30) put(8'($urandom_range(8'h41, 8'h5A)), 1'b1);
				send_text();
			end else begin
				repeat ($urandom_range(1, 10)) add_fragment();
				// some streams are cut off mid-construct
				if ($urandom_range(0, 9) == 0) begin
					cut = $urandom_range(1, text.size());
					while (text.size() > cut)
						void'(text.pop_back());
				end
				// some end on a held slash
				if ($urandom_range(0, 9) == 0)
					put(CH_SLASH, 1'b1);
				no_idle = ($urandom_range(0, 3) == 0);
				send_text();
			end
			if ($urandom_range(0, 19) == 0) begin
				go_idle();
				wait (pending == 0);
			end
		end

		go_idle();
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d source bytes in %0d streams, %0d output words compared",
			bytes_sent, streams, checked);
		$display("comments, strings, raw strings, lone and trailing slashes, noise; %0d errors",
			mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== source_comment_stripper_top.f =====
design/csstrip_pkg.sv
design/csstrip_front.sv
design/csstrip_queue.sv
design/csstrip_back.sv
design/source_comment_stripper_top.sv
tb/stripper_checker.sv
tb/tb.sv
